>>> sv/ute_pkg.sv
// ----------------------------------------------------------------------------
// ute_pkg
// Shared types, constants and the UTF-8 byte encoder of the UTF-16 to UTF-8
// transcoder.
// ----------------------------------------------------------------------------
package ute_pkg;

   localparam int UNIT_W    = 16;
   localparam int COUNT_W   = 32;
   localparam int BYTE_W    = 8;
   localparam int CP_W      = 21;
   localparam int MAX_BYTES = 6;
   localparam int IDX_W     = 3;
   localparam int LEN_W     = 3;

   localparam logic [5:0]      HIGH_SURR_TAG = 6'b110110;
   localparam logic [5:0]      LOW_SURR_TAG  = 6'b110111;
   localparam logic [CP_W-1:0] SUPP_BASE     = 21'h10000;
   localparam logic [CP_W-1:0] REPLACEMENT   = 21'h00FFFD;

   typedef logic [CP_W-1:0]   cp_type;
   typedef logic [BYTE_W-1:0] octet_type;

   typedef struct packed {
      logic [3:0][BYTE_W-1:0] bytes;   // bytes[0] goes out first
      logic [LEN_W-1:0]       len;
   } enc_type;

   typedef struct packed {
      logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
      logic [LEN_W-1:0]                 n;
      logic [COUNT_W-1:0]               base;
      logic                             full;
      logic                             eos;
   } plan_type;

   function automatic enc_type encode(input cp_type cp);
      enc_type e;
      e.bytes = '0;
      if (cp < 21'h80) begin
         e.len      = 3'd1;
         e.bytes[0] = {1'b0, cp[6:0]};
      end else if (cp < 21'h800) begin
         e.len      = 3'd2;
         e.bytes[0] = {3'b110, cp[10:6]};
         e.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
         e.len      = 3'd3;
         e.bytes[0] = {4'b1110, cp[15:12]};
         e.bytes[1] = {2'b10, cp[11:6]};
         e.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         e.len      = 3'd4;
         e.bytes[0] = {5'b11110, cp[20:18]};
         e.bytes[1] = {2'b10, cp[17:12]};
         e.bytes[2] = {2'b10, cp[11:6]};
         e.bytes[3] = {2'b10, cp[5:0]};
      end
      return e;
   endfunction

endpackage

>>> sv/ute_req_if.sv
// ----------------------------------------------------------------------------
// ute_req_if
// Input channel: one UTF-16 code unit per item with an end-of-string flag.
// ----------------------------------------------------------------------------
interface ute_req_if;
   logic                         valid;
   logic                         ready;
   logic [ute_pkg::UNIT_W-1:0]   code_unit;
   logic                         end_of_string;

   modport source(output valid, code_unit, end_of_string, input ready);
   modport sink(input valid, code_unit, end_of_string, output ready);
endinterface

>>> sv/ute_rsp_if.sv
// ----------------------------------------------------------------------------
// ute_rsp_if
// Result channel: one UTF-8 byte or a status-only result per item.
// ----------------------------------------------------------------------------
interface ute_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ute_pkg::BYTE_W-1:0]    data_byte;
   logic                          byte_valid;
   logic                          last_of_run;
   logic [ute_pkg::COUNT_W-1:0]   bytes_written;
   logic                          stopped;

   modport source(output valid, data_byte, byte_valid, last_of_run, bytes_written,
                  stopped, input ready);
   modport sink(input valid, data_byte, byte_valid, last_of_run, bytes_written,
                stopped, output ready);
endinterface

>>> sv/utf16_to_utf8_encoder_top.sv
// Path: an accepted item is loaded into the byte plan register; each of its results
// then passes through the result register, which holds it while the output stalls.
// Throughput: one result per cycle from the result register while the output is not
// stalled; the input waits until the current item's last result is sent, and an item
// without results is not loaded. The byte plan register feeding it sets that rate.
// Reset: synchronous, active high; clears the pending surrogate, count, stop flag,
// the capacity register (to zero) and both valid flags.
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_top
// UTF-16 to UTF-8 transcoder with destination capacity limit.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder_top (
   input  logic                          clock,
   input  logic                          reset,
   ute_req_if.sink                       req_ch,
   ute_rsp_if.source                     rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [ute_pkg::COUNT_W-1:0]   csr_wr_data
);

   logic [ute_pkg::COUNT_W-1:0]   cap_ff, cap_in;
   ute_pkg::plan_type             plan;
   logic                          keep, free, accept;

   assign cap_in = csr_wr_en ? csr_wr_data : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= '0;
      end else begin
         cap_ff <= cap_in;
      end
   end

   assign req_ch.ready = free;
   assign accept       = req_ch.valid && free;

   ute_planner u_planner (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .code_unit     (req_ch.code_unit),
      .end_of_string (req_ch.end_of_string),
      .capacity      (cap_ff),
      .plan          (plan),
      .keep          (keep)
   );

   ute_serializer u_serializer (
      .clock             (clock),
      .reset             (reset),
      .load              (accept && keep),
      .plan              (plan),
      .free              (free),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_data_byte     (rsp_ch.data_byte),
      .rsp_byte_valid    (rsp_ch.byte_valid),
      .rsp_last_of_run   (rsp_ch.last_of_run),
      .rsp_bytes_written (rsp_ch.bytes_written),
      .rsp_stopped       (rsp_ch.stopped)
   );

endmodule

>>> sv/ute_planner.sv
// ----------------------------------------------------------------------------
// ute_planner
// Surrogate pairing, capacity check and byte layout for one code unit; holds
// the pending high surrogate, the byte count and the stop flag.
// ----------------------------------------------------------------------------
module ute_planner (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [ute_pkg::UNIT_W-1:0]    code_unit,
   input  logic                          end_of_string,
   input  logic [ute_pkg::COUNT_W-1:0]   capacity,
   output ute_pkg::plan_type             plan,
   output logic                          keep
);

   logic [9:0]                    pend_high_ff, pend_high_in;
   logic                          pend_valid_ff, pend_valid_in;
   logic [ute_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                          full_ff, full_in;

   logic                 is_high, is_low;
   logic                 p0_v, p1_v;
   ute_pkg::cp_type      p0_cp, p1_cp;
   ute_pkg::enc_type     enc0, enc1;
   logic [ute_pkg::COUNT_W:0] cnt_x, cap_x, sum0, sum1, sum01, cnt_next;
   logic                 fits0, fits1, emit0, emit1, full0, full_after;
   logic [ute_pkg::LEN_W-1:0] n0, n1;

   assign is_high = (code_unit[15:10] == ute_pkg::HIGH_SURR_TAG);
   assign is_low  = (code_unit[15:10] == ute_pkg::LOW_SURR_TAG);

   // at most two code points per unit: a flushed or paired one, then the unit
   always_comb begin
      p0_v  = pend_valid_ff;
      p0_cp = ute_pkg::REPLACEMENT;
      p1_v  = 1'b1;
      p1_cp = ute_pkg::REPLACEMENT;
      if (pend_valid_ff && is_low) begin
         p0_cp = ute_pkg::SUPP_BASE + {1'b0, pend_high_ff, code_unit[9:0]};
         p1_v  = 1'b0;
      end else if (is_high) begin
         p1_v = end_of_string;
      end else if (!is_low) begin
         p1_cp = {5'd0, code_unit};
      end
   end

   assign enc0 = ute_pkg::encode(p0_cp);
   assign enc1 = ute_pkg::encode(p1_cp);

   assign cnt_x = {1'b0, count_ff};
   assign cap_x = {1'b0, capacity};
   assign sum0  = cnt_x + {30'd0, enc0.len};
   assign sum1  = cnt_x + {30'd0, enc1.len};
   assign sum01 = cnt_x + {30'd0, enc0.len} + {30'd0, enc1.len};

   assign fits0      = (sum0 <= cap_x);
   assign emit0      = p0_v && !full_ff && fits0;
   assign full0      = full_ff || (p0_v && !fits0);
   assign fits1      = emit0 ? (sum01 <= cap_x) : (sum1 <= cap_x);
   assign emit1      = p1_v && !full0 && fits1;
   assign full_after = full0 || (p1_v && !full0 && !fits1);

   assign n0 = emit0 ? enc0.len : '0;
   assign n1 = emit1 ? enc1.len : '0;

   always_comb begin
      if (emit1) begin
         cnt_next = emit0 ? sum01 : sum1;
      end else begin
         cnt_next = emit0 ? sum0 : cnt_x;
      end
   end

   always_comb begin
      logic [ute_pkg::IDX_W-1:0] j;
      plan.bytes = '0;
      for (int i = 0; i < ute_pkg::MAX_BYTES; i++) begin
         j = ute_pkg::IDX_W'(i) - n0;
         if (ute_pkg::IDX_W'(i) < n0) begin
            plan.bytes[i] = enc0.bytes[i[1:0]];
         end else if (j < 3'd4) begin
            plan.bytes[i] = enc1.bytes[j[1:0]];
         end
      end
      plan.n    = n0 + n1;
      plan.base = count_ff;
      plan.full = full_after;
      plan.eos  = end_of_string;
   end

   assign keep = end_of_string || (plan.n != '0);

   always_comb begin
      pend_high_in  = pend_high_ff;
      pend_valid_in = pend_valid_ff;
      count_in      = count_ff;
      full_in       = full_ff;
      if (accept) begin
         if (end_of_string) begin
            pend_high_in  = '0;
            pend_valid_in = 1'b0;
            count_in      = '0;
            full_in       = 1'b0;
         end else begin
            pend_valid_in = is_high && !(pend_valid_ff && is_low);
            if (is_high) begin
               pend_high_in = code_unit[9:0];
            end
            count_in = cnt_next[ute_pkg::COUNT_W-1:0];
            full_in  = full_after;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_high_ff  <= '0;
         pend_valid_ff <= 1'b0;
         count_ff      <= '0;
         full_ff       <= 1'b0;
      end else begin
         pend_high_ff  <= pend_high_in;
         pend_valid_ff <= pend_valid_in;
         count_ff      <= count_in;
         full_ff       <= full_in;
      end
   end

endmodule

>>> sv/ute_serializer.sv
// ----------------------------------------------------------------------------
// ute_serializer
// Holds the byte plan of one item and sends it one result per cycle into the
// result register whenever that register is empty or being taken.
// ----------------------------------------------------------------------------
module ute_serializer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  ute_pkg::plan_type             plan,
   output logic                          free,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [ute_pkg::BYTE_W-1:0]    rsp_data_byte,
   output logic                          rsp_byte_valid,
   output logic                          rsp_last_of_run,
   output logic [ute_pkg::COUNT_W-1:0]   rsp_bytes_written,
   output logic                          rsp_stopped
);

   ute_pkg::plan_type             plan_ff, plan_in;
   logic                          plan_valid_ff, plan_valid_in;
   logic [ute_pkg::IDX_W-1:0]     idx_ff, idx_in;

   logic                          out_valid_ff, out_valid_in;
   logic [ute_pkg::BYTE_W-1:0]    data_ff, data_in;
   logic                          bvalid_ff, bvalid_in;
   logic                          last_ff, last_in;
   logic [ute_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                          stop_ff, stop_in;

   logic                          emit, last_res, status_only;
   logic [ute_pkg::IDX_W-1:0]     n_res;

   assign status_only = (plan_ff.n == '0);
   assign n_res       = status_only ? ute_pkg::IDX_W'(1) : plan_ff.n;
   assign last_res    = (idx_ff == n_res - ute_pkg::IDX_W'(1));
   assign emit        = plan_valid_ff && (!out_valid_ff || rsp_ready);
   assign free        = !plan_valid_ff || (emit && last_res);

   always_comb begin
      plan_in       = plan_ff;
      plan_valid_in = plan_valid_ff;
      idx_in        = idx_ff;
      if (load) begin
         plan_in       = plan;
         plan_valid_in = 1'b1;
         idx_in        = '0;
      end else if (emit && last_res) begin
         plan_valid_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + ute_pkg::IDX_W'(1);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      data_in      = data_ff;
      bvalid_in    = bvalid_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      stop_in      = stop_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         bvalid_in    = !status_only;
         data_in      = status_only ? '0 : plan_ff.bytes[idx_ff];
         last_in      = last_res;
         count_in     = status_only ? plan_ff.base
                        : plan_ff.base + ute_pkg::COUNT_W'(idx_ff) + ute_pkg::COUNT_W'(1);
         stop_in      = plan_ff.full;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plan_valid_ff <= 1'b0;
         idx_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         plan_valid_ff <= plan_valid_in;
         idx_ff        <= idx_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plan_ff  <= plan_in;
      data_ff  <= data_in;
      bvalid_ff <= bvalid_in;
      last_ff  <= last_in;
      count_ff <= count_in;
      stop_ff  <= stop_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_data_byte     = data_ff;
   assign rsp_byte_valid    = bvalid_ff;
   assign rsp_last_of_run   = last_ff;
   assign rsp_bytes_written = count_ff;
   assign rsp_stopped       = stop_ff;

endmodule

>>> sv/ute_checker.sv
// ----------------------------------------------------------------------------
// ute_checker
// Port-level checks on the transcoder result channel.
// ----------------------------------------------------------------------------
module ute_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [ute_pkg::BYTE_W-1:0]    rsp_data_byte,
   input logic                          rsp_byte_valid,
   input logic                          rsp_last_of_run,
   input logic [ute_pkg::COUNT_W-1:0]   rsp_bytes_written,
   input logic                          rsp_stopped
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_byte)
         && $stable(rsp_bytes_written) && $stable(rsp_last_of_run)
         && $stable(rsp_byte_valid) && $stable(rsp_stopped))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // status-only item closes the run and carries no byte
   a_status_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_last_of_run && (rsp_data_byte == '0))
      else $error("malformed status-only result");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> (rsp_bytes_written != '0))
      else $error("byte result with zero count");

endmodule

bind utf16_to_utf8_encoder_top ute_checker u_ute_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_data_byte     (rsp_ch.data_byte),
   .rsp_byte_valid    (rsp_ch.byte_valid),
   .rsp_last_of_run   (rsp_ch.last_of_run),
   .rsp_bytes_written (rsp_ch.bytes_written),
   .rsp_stopped       (rsp_ch.stopped)
);

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-16 to UTF-8 transcoder.
// Code units go in with random gaps while the result side stalls at random.
// A transcoder model in the bench predicts every output byte and status item,
// and each one is compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb;

   localparam int HALF_PERIOD  = 6;
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int MAX_REPORTS  = 40;

   typedef enum {
      UNIT_ASCII,
      UNIT_TWO_BYTE,
      UNIT_THREE_BYTE,
      UNIT_PAIR,
      UNIT_LONE_HIGH,
      UNIT_LONE_LOW,
      UNIT_ANY
   } unit_kind_type;

   typedef struct packed {
      ute_pkg::octet_type          data_byte;
      logic                        byte_valid;
      logic                        last_of_run;
      logic [ute_pkg::COUNT_W-1:0] bytes_written;
      logic                        stopped;
   } utf8_item_type;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        csr_wr_en;
   logic [ute_pkg::COUNT_W-1:0] csr_wr_data;

   ute_req_if req_ch();
   ute_rsp_if rsp_ch();

   utf16_to_utf8_encoder_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // transcoder state as the bench tracks it
   logic [ute_pkg::COUNT_W-1:0] capacity;
   logic [9:0]                  held_high;
   logic                        held_valid;
   logic [ute_pkg::COUNT_W-1:0] byte_count;
   logic                        capacity_hit;
   ute_pkg::octet_type          point_bytes[$];
   logic [ute_pkg::COUNT_W-1:0] point_counts[$];
   utf8_item_type               expected_bytes[$];

   int send_idle_pct;
   int rsp_stall_pct;
   int hold_left;
   int err_count;
   int quiet_cycles;

   always #HALF_PERIOD clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      err_count++;
      if (err_count <= MAX_REPORTS)
         $display("error at %0t: %s got %0h expected %0h", $time, what, got, want);
   endtask

   task automatic append_byte(input ute_pkg::octet_type b);
      byte_count = byte_count + 1;
      point_bytes.push_back(b);
      point_counts.push_back(byte_count);
   endtask

   task automatic encode_point(input ute_pkg::cp_type cp);
      int unsigned                 len;
      logic [ute_pkg::COUNT_W:0]   needed;
      if (capacity_hit)
         return;
      if (cp < 21'h80)
         len = 1;
      else if (cp < 21'h800)
         len = 2;
      else if (cp < ute_pkg::SUPP_BASE)
         len = 3;
      else
         len = 4;
      needed = {1'b0, byte_count} + len;
      // stop on a whole code point, never a partial one
      if (needed > {1'b0, capacity}) begin
         capacity_hit = 1'b1;
         return;
      end
      case (len)
         1: append_byte(cp[7:0]);
         2: begin
            append_byte(8'hC0 | cp[10:6]);
            append_byte(8'h80 | cp[5:0]);
         end
         3: begin
            append_byte(8'hE0 | cp[15:12]);
            append_byte(8'h80 | cp[11:6]);
            append_byte(8'h80 | cp[5:0]);
         end
         default: begin
            append_byte(8'hF0 | cp[20:18]);
            append_byte(8'h80 | cp[17:12]);
            append_byte(8'h80 | cp[11:6]);
            append_byte(8'h80 | cp[5:0]);
         end
      endcase
   endtask

   task automatic transcode_unit(input logic [ute_pkg::UNIT_W-1:0] cu16, input logic eos);
      logic          is_high;
      logic          is_low;
      int            n;
      utf8_item_type r;
      is_high = (cu16[15:10] == ute_pkg::HIGH_SURR_TAG);
      is_low  = (cu16[15:10] == ute_pkg::LOW_SURR_TAG);
      point_bytes.delete();
      point_counts.delete();
      if (held_valid && is_low) begin
         encode_point(ute_pkg::SUPP_BASE + {held_high, cu16[9:0]});
         held_valid = 1'b0;
      end else begin
         // an unpaired high surrogate turns into the replacement character
         if (held_valid) begin
            encode_point(ute_pkg::REPLACEMENT);
            held_valid = 1'b0;
         end
         if (is_high) begin
            held_high  = cu16[9:0];
            held_valid = 1'b1;
         end else if (is_low) begin
            encode_point(ute_pkg::REPLACEMENT);
         end else begin
            encode_point({5'd0, cu16});
         end
      end
      if (eos && held_valid) begin
         encode_point(ute_pkg::REPLACEMENT);
         held_valid = 1'b0;
      end
      n = point_bytes.size();
      for (int k = 0; k < n; k++) begin
         r.data_byte     = point_bytes[k];
         r.byte_valid    = 1'b1;
         r.last_of_run   = (k == n - 1);
         r.bytes_written = point_counts[k];
         r.stopped       = capacity_hit;
         expected_bytes.push_back(r);
      end
      if (eos) begin
         // end item with no bytes still reports the total
         if (n == 0) begin
            r.data_byte     = '0;
            r.byte_valid    = 1'b0;
            r.last_of_run   = 1'b1;
            r.bytes_written = byte_count;
            r.stopped       = capacity_hit;
            expected_bytes.push_back(r);
         end
         held_high    = '0;
         held_valid   = 1'b0;
         byte_count   = '0;
         capacity_hit = 1'b0;
      end
   endtask

   task automatic push_unit(input logic [ute_pkg::UNIT_W-1:0] cu16, input logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid         <= 1'b1;
      req_ch.code_unit     <= cu16;
      req_ch.end_of_string <= eos;
      do @(posedge clock); while (!req_ch.ready);
      transcode_unit(cu16, eos);
   endtask

   task automatic wait_drain;
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_bytes.size() != 0)
         @(posedge clock);
      // a held surrogate yields nothing, so give the pipeline time to settle
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [ute_pkg::COUNT_W-1:0] value);
      wait_drain();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      capacity = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_random_string(inout int sent);
      logic [ute_pkg::UNIT_W-1:0] units[$];
      int                         len;
      int                         pick;
      unit_kind_type              kind;
      len = $urandom_range(10, 1);
      while (units.size() < len) begin
         pick = $urandom_range(99);
         kind = pick < 25 ? UNIT_ASCII :
                pick < 40 ? UNIT_TWO_BYTE :
                pick < 60 ? UNIT_THREE_BYTE :
                pick < 80 ? UNIT_PAIR :
                pick < 86 ? UNIT_LONE_HIGH :
                pick < 92 ? UNIT_LONE_LOW : UNIT_ANY;
         case (kind)
            UNIT_ASCII:    units.push_back(16'($urandom_range(16'h007F, 16'h0000)));
            UNIT_TWO_BYTE: units.push_back(16'($urandom_range(16'h07FF, 16'h0080)));
            UNIT_THREE_BYTE: begin
               if ($urandom_range(1))
                  units.push_back(16'($urandom_range(16'hD7FF, 16'h0800)));
               else
                  units.push_back(16'($urandom_range(16'hFFFF, 16'hE000)));
            end
            UNIT_PAIR: begin
               units.push_back({ute_pkg::HIGH_SURR_TAG, 10'($urandom)});
               units.push_back({ute_pkg::LOW_SURR_TAG, 10'($urandom)});
            end
            UNIT_LONE_HIGH: units.push_back({ute_pkg::HIGH_SURR_TAG, 10'($urandom)});
            UNIT_LONE_LOW:  units.push_back({ute_pkg::LOW_SURR_TAG, 10'($urandom)});
            default:        units.push_back(16'($urandom));
         endcase
      end
      foreach (units[i])
         push_unit(units[i], i == units.size() - 1);
      sent += units.size();
   endtask

   // capacity still at its reset value of zero: every byte is dropped
   task automatic test_reset_capacity;
      push_unit(16'h0041, 1'b0);
      push_unit(16'h0000, 1'b1);
   endtask

   task automatic test_code_point_sizes;
      set_capacity('1);
      push_unit(16'h0000, 1'b0);
      push_unit(16'h007F, 1'b0);
      push_unit(16'h0080, 1'b0);
      push_unit(16'h07FF, 1'b0);
      push_unit(16'h0800, 1'b0);
      push_unit(16'hFFFF, 1'b1);
   endtask

   task automatic test_surrogates;
      push_unit(16'hD800, 1'b0);
      push_unit(16'hDC00, 1'b0);
      push_unit(16'hDBFF, 1'b0);
      push_unit(16'hDFFF, 1'b0);
      push_unit(16'hDC00, 1'b0);
      push_unit(16'hD800, 1'b0);
      push_unit(16'h0041, 1'b0);
      // high after high, then the end flushes the second one
      push_unit(16'hD800, 1'b0);
      push_unit(16'hDBFF, 1'b1);
   endtask

   task automatic test_capacity_stop;
      set_capacity(32'd5);
      push_unit(16'h0041, 1'b0);
      push_unit(16'h4E2D, 1'b0);
      push_unit(16'h00E9, 1'b0);
      push_unit(16'h0041, 1'b0);
      push_unit(16'h0042, 1'b1);
   endtask

   task automatic test_capacity_change;
      set_capacity(32'd3);
      push_unit(16'h0041, 1'b0);
      push_unit(16'h0042, 1'b0);
      set_capacity(32'd6);
      push_unit(16'h20AC, 1'b0);
      push_unit(16'h0043, 1'b1);
   endtask

   task automatic test_random_phase(input int send_pct, input int stall_pct, input int n);
      int                          sent;
      int                          pick;
      logic [ute_pkg::COUNT_W-1:0] cap;
      sent          = 0;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      while (sent < n) begin
         pick = $urandom_range(2);
         cap  = pick == 0 ? $urandom_range(24) : pick == 1 ? $urandom : '1;
         set_capacity(cap);
         repeat (4) send_random_string(sent);
      end
   endtask

   task automatic test_backpressure;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      set_capacity('1);
      hold_left = HOLD_CYCLES;
      for (int i = 0; i < 24; i++)
         push_unit(16'($urandom_range(16'hD7FF, 16'h0800)), i == 23);
   endtask

   // result side: a long hold-off while one is armed, otherwise random stalls
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : check_results
      utf8_item_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch("item with nothing expected, data_byte",
                            32'(rsp_ch.data_byte), 32'd0);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_ch.data_byte !== want.data_byte)
               report_mismatch("data_byte", 32'(rsp_ch.data_byte), 32'(want.data_byte));
            if (rsp_ch.byte_valid !== want.byte_valid)
               report_mismatch("byte_valid", 32'(rsp_ch.byte_valid),
                               32'(want.byte_valid));
            if (rsp_ch.last_of_run !== want.last_of_run)
               report_mismatch("last_of_run", 32'(rsp_ch.last_of_run),
                               32'(want.last_of_run));
            if (rsp_ch.bytes_written !== want.bytes_written)
               report_mismatch("bytes_written", rsp_ch.bytes_written, want.bytes_written);
            if (rsp_ch.stopped !== want.stopped)
               report_mismatch("stopped", 32'(rsp_ch.stopped), 32'(want.stopped));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
         $display("utf16_to_utf8_encoder_top: mismatch");
         $finish;
      end
   end

   initial begin
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_ch.valid         = 1'b0;
      req_ch.code_unit     = '0;
      req_ch.end_of_string = 1'b0;
      rsp_ch.ready         = 1'b0;
      capacity             = '0;
      held_high            = '0;
      held_valid           = 1'b0;
      byte_count           = '0;
      capacity_hit         = 1'b0;
      send_idle_pct        = 0;
      rsp_stall_pct        = 0;
      hold_left            = 0;
      err_count            = 0;
      quiet_cycles         = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_capacity();
      test_code_point_sizes();
      test_surrogates();
      test_capacity_stop();
      test_capacity_change();
      test_random_phase(0, 0, 40);
      test_random_phase(74, 0, 40);
      test_random_phase(0, 74, 40);
      test_random_phase(13, 13, 40);
      test_backpressure();

      wait_drain();
      if (err_count == 0)
         $display("utf16_to_utf8_encoder_top: match");
      else
         $display("utf16_to_utf8_encoder_top: mismatch");
      $finish;
   end

endmodule
